// ===== rtl/abb_pkg.sv =====
// shared types, constants and elaboration-time helpers for the arc bounding box
package abb_pkg;

   localparam int COORD_W = 40;
   localparam int RADIUS_W = 39;
   localparam int TOL_W = 16;
   localparam int PTW = COORD_W + 2;
   localparam int R_LO = 20;
   localparam int COORD_FRAC = 16;

   // cordic precision: fraction bits and rotation steps
   localparam int CF = 56;
   localparam int CN = 54;
   localparam int CXW = CF + 2;
   localparam int CZW = CF + 2;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NEAR_TOL = 2'd1;

   localparam logic [63:0] LIMIT_RAW = 64'd100000 << COORD_FRAC;
   localparam logic [63:0] LIMIT_MAX = (64'd1 << RADIUS_W) - 64'd1;
   localparam logic [RADIUS_W-1:0] LIMIT_RESET =
      RADIUS_W'((LIMIT_RAW > LIMIT_MAX) ? LIMIT_MAX : LIMIT_RAW);

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   localparam real PI_VAL = 3.14159265358979323846;
   // radians to quarter turns with CF fraction bits
   localparam real TURN_SCALE = (2.0 ** CF) * 2.0 / PI_VAL;

   typedef enum logic [1:0] {
      QUAD_I   = 2'd0,
      QUAD_II  = 2'd1,
      QUAD_III = 2'd2,
      QUAD_IV  = 2'd3
   } quad_type;

   typedef struct packed {
      logic xmin;
      logic xmax;
      logic ymin;
      logic ymax;
   } ext_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic [RADIUS_W-1:0]       r;
      quad_type                  qs;
      quad_type                  qe;
      ext_type                   ext;
   } side_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] max_y;
   } box_type;

   // rotation angle of step i in quarter turns, CF fraction bits
   function automatic logic signed [CZW-1:0] atan_step(input int i);
      real a;
      a = $atan(2.0 ** (-i)) * TURN_SCALE;
      return CZW'(longint'(a));
   endfunction

   // start magnitude that cancels the cordic growth
   function automatic logic signed [CXW-1:0] cordic_gain();
      real g;
      g = 1.0;
      for (int k = 0; k < CN; k++) begin
         g = g * $pow(1.0 + 2.0 ** (-2 * k), -0.5);
      end
      return CXW'(longint'(g * (2.0 ** CF)));
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PTW-1:0] v);
      logic signed [COORD_W-1:0] res;
      if (!v[PTW-1] && (v[PTW-2:COORD_W-1] != '0)) begin
         res = COORD_MAX;
      end else if (v[PTW-1] && (v[PTW-2:COORD_W-1] != '1)) begin
         res = COORD_MIN;
      end else begin
         res = v[COORD_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/abb_cordic.sv =====
// pipelined cordic giving rounded, scaled cosine and sine of a first-quadrant angle
module abb_cordic
   import abb_pkg::*;
#(
   parameter int SINE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [CZW-1:0]       angle_z,
   output logic [SINE_BITS-2:0] cos_mag,
   output logic [SINE_BITS-2:0] sin_mag
);

   localparam logic signed [CXW-1:0] GAIN = cordic_gain();
   localparam int RW = CXW + SINE_BITS;
   localparam logic signed [RW-1:0] RND = {{(RW-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};

   logic signed [CXW-1:0] x_ff [CN];
   logic signed [CXW-1:0] y_ff [CN];
   logic signed [CZW-1:0] z_ff [CN];

   for (genvar g = 0; g < CN; g++) begin : g_step
      localparam logic signed [CZW-1:0] ANG = atan_step(g);
      logic signed [CXW-1:0] xp;
      logic signed [CXW-1:0] yp;
      logic signed [CZW-1:0] zp;
      logic signed [CXW-1:0] x_in;
      logic signed [CXW-1:0] y_in;
      logic signed [CZW-1:0] z_in;

      if (g == 0) begin : g_first
         assign xp = GAIN;
         assign yp = '0;
         assign zp = $signed(angle_z);
      end else begin : g_next
         assign xp = x_ff[g-1];
         assign yp = y_ff[g-1];
         assign zp = z_ff[g-1];
      end

      always_comb begin
         if (!zp[CZW-1]) begin
            x_in = xp - (yp >>> g);
            y_in = yp + (xp >>> g);
            z_in = zp - ANG;
         end else begin
            x_in = xp + (yp >>> g);
            y_in = yp - (xp >>> g);
            z_in = zp + ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[g] <= x_in;
            y_ff[g] <= y_in;
            z_ff[g] <= z_in;
         end
      end
   end

   // round amplitude * value, amplitude = 2^(SINE_BITS-1) - 1
   logic signed [RW-1:0]  xr;
   logic signed [RW-1:0]  yr;
   logic [SINE_BITS-2:0]  cos_ff;
   logic [SINE_BITS-2:0]  sin_ff;
   logic [SINE_BITS-2:0]  cos_in;
   logic [SINE_BITS-2:0]  sin_in;

   always_comb begin
      xr = (RW'(x_ff[CN-1]) <<< (SINE_BITS - 1)) - RW'(x_ff[CN-1]) + RND;
      yr = (RW'(y_ff[CN-1]) <<< (SINE_BITS - 1)) - RW'(y_ff[CN-1]) + RND;
      cos_in = xr[CF+SINE_BITS-2:CF];
      sin_in = yr[CF+SINE_BITS-2:CF];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_mag = cos_ff;
   assign sin_mag = sin_ff;

endmodule

// ===== rtl/arc_bounding_box.sv =====
// arc bounding box top level: angle prep, two cordics, end points, box merge, output buffer
//
// channel   dir   handshake              payload
// req       in    req_valid, req_stall   center x/y, radius, start/end angle, clockwise
// rsp       out   rsp_valid, rsp_stall   min_x, min_y, max_x, max_y
// csr       in    csr_wr_en              csr_index, csr_wdata
//
// one request per cycle while req_stall is low
// the longest part of the pipeline is the 54-step cordic that turns each angle into cosine and sine
// reset clears all valid bits and loads the register defaults
// rsp has an output register and one skid entry; req stalls only while the skid is full
module arc_bounding_box
   import abb_pkg::*;
#(
   parameter int ANGLE_BITS = 16,
   parameter int SINE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [COORD_W-1:0]   req_center_x,
   input  logic signed [COORD_W-1:0]   req_center_y,
   input  logic [RADIUS_W-1:0]         req_arc_radius,
   input  logic [ANGLE_BITS-1:0]       req_start_angle,
   input  logic [ANGLE_BITS-1:0]       req_end_angle,
   input  logic                        req_clockwise,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [COORD_W-1:0]   rsp_min_x,
   output logic signed [COORD_W-1:0]   rsp_min_y,
   output logic signed [COORD_W-1:0]   rsp_max_x,
   output logic signed [COORD_W-1:0]   rsp_max_y,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [RADIUS_W-1:0]         csr_wdata
);

   localparam int LAST = CN + 7;
   localparam int CO = CN + 1;
   localparam int PLW = SINE_BITS + R_LO + 1;
   localparam int PHW = SINE_BITS + RADIUS_W - R_LO + 1;
   localparam int PRW = SINE_BITS + RADIUS_W + 1;
   localparam int PSX = 0;
   localparam int PSY = 1;
   localparam int PEX = 2;
   localparam int PEY = 3;
   localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};
   localparam logic [ANGLE_BITS-1:0] HALF = {2'b10, {(ANGLE_BITS-2){1'b0}}};
   localparam logic [ANGLE_BITS-1:0] THREE = {2'b11, {(ANGLE_BITS-2){1'b0}}};

   // config registers
   logic [RADIUS_W-1:0] lim_ff;
   logic [TOL_W-1:0]    tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= LIMIT_RESET;
         tol_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_RADIUS_LIMIT: lim_ff <= csr_wdata;
            REG_NEAR_TOL:     tol_ff <= csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic            en;
   logic [LAST:0]   v_ff;
   logic            out_v_ff;
   logic            skid_v_ff;

   assign en = !skid_v_ff;
   assign req_stall = skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAST-1:0], req_valid};
      end
   end

   // request prep: quadrant, residue angle, crossing flags
   logic [ANGLE_BITS-1:0] a1;
   logic [ANGLE_BITS-1:0] a2;
   logic                  wrap;
   side_type              side_in;
   logic [CZW-1:0]        zs_in;
   logic [CZW-1:0]        ze_in;

   always_comb begin
      a1 = req_clockwise ? req_end_angle : req_start_angle;
      a2 = req_clockwise ? req_start_angle : req_end_angle;
      wrap = a1 >= a2;
      side_in.cx = req_center_x;
      side_in.cy = req_center_y;
      side_in.r = req_arc_radius;
      side_in.qs = quad_type'(req_start_angle[ANGLE_BITS-1:ANGLE_BITS-2]);
      side_in.qe = quad_type'(req_end_angle[ANGLE_BITS-1:ANGLE_BITS-2]);
      side_in.ext.xmin = (a1 < HALF && a2 > HALF) || (wrap && (a2 > HALF || a1 < HALF));
      side_in.ext.xmax = wrap;
      side_in.ext.ymin = (a1 < THREE && a2 > THREE) || (wrap && (a2 > THREE || a1 < THREE));
      side_in.ext.ymax = (a1 < QUARTER && a2 > QUARTER) ||
                         (wrap && (a2 > QUARTER || a1 < QUARTER));
      zs_in = {2'b00, req_start_angle[ANGLE_BITS-3:0], {(CF-ANGLE_BITS+2){1'b0}}};
      ze_in = {2'b00, req_end_angle[ANGLE_BITS-3:0], {(CF-ANGLE_BITS+2){1'b0}}};
   end

   side_type       side_ff [CO+1];
   logic [CZW-1:0] zs_ff;
   logic [CZW-1:0] ze_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         zs_ff <= zs_in;
         ze_ff <= ze_in;
         for (int k = 1; k <= CO; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // cosine and sine of both angles
   logic [SINE_BITS-2:0] mag_c [2];
   logic [SINE_BITS-2:0] mag_s [2];

   abb_cordic #(.SINE_BITS(SINE_BITS)) u_cordic_start (
      .clock   (clock),
      .en      (en),
      .angle_z (zs_ff),
      .cos_mag (mag_c[0]),
      .sin_mag (mag_s[0])
   );

   abb_cordic #(.SINE_BITS(SINE_BITS)) u_cordic_end (
      .clock   (clock),
      .en      (en),
      .angle_z (ze_ff),
      .cos_mag (mag_c[1]),
      .sin_mag (mag_s[1])
   );

   // quadrant fold and radius partial products
   quad_type                    quad [2];
   logic signed [SINE_BITS-1:0] cpos;
   logic signed [SINE_BITS-1:0] spos;
   logic signed [SINE_BITS-1:0] coef [4];
   logic signed [PLW-1:0]       pl_in [4];
   logic signed [PHW-1:0]       ph_in [4];
   logic signed [PLW-1:0]       pl_ff [4];
   logic signed [PHW-1:0]       ph_ff [4];
   side_type                    m1_ff;

   always_comb begin
      quad[0] = side_ff[CO].qs;
      quad[1] = side_ff[CO].qe;
      for (int e = 0; e < 2; e++) begin
         cpos = $signed({1'b0, mag_c[e]});
         spos = $signed({1'b0, mag_s[e]});
         case (quad[e])
            QUAD_I: begin
               coef[2*e] = cpos;
               coef[2*e+1] = spos;
            end
            QUAD_II: begin
               coef[2*e] = -spos;
               coef[2*e+1] = cpos;
            end
            QUAD_III: begin
               coef[2*e] = -cpos;
               coef[2*e+1] = -spos;
            end
            default: begin
               coef[2*e] = spos;
               coef[2*e+1] = -cpos;
            end
         endcase
      end
      for (int k = 0; k < 4; k++) begin
         pl_in[k] = PLW'($signed({1'b0, side_ff[CO].r[R_LO-1:0]})) * PLW'(coef[k]);
         ph_in[k] = PHW'($signed({1'b0, side_ff[CO].r[RADIUS_W-1:R_LO]})) * PHW'(coef[k]);
      end
   end

   // product sum, then floor shift plus center
   logic signed [PRW-1:0] pr_ff [4];
   logic signed [PTW-1:0] pt_ff [4];
   side_type              m2_ff;
   side_type              m3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff <= side_ff[CO];
         m2_ff <= m1_ff;
         m3_ff <= m2_ff;
         for (int k = 0; k < 4; k++) begin
            pl_ff[k] <= pl_in[k];
            ph_ff[k] <= ph_in[k];
            pr_ff[k] <= (PRW'(ph_ff[k]) <<< R_LO) + PRW'(pl_ff[k]);
            pt_ff[k] <= PTW'(k[0] ? m2_ff.cy : m2_ff.cx) +
                        PTW'(pr_ff[k] >>> (SINE_BITS - 1));
         end
      end
   end

   // end point box, circle extremes, end point spread
   logic signed [PTW-1:0] rr;
   logic signed [PTW-1:0] lo_x_ff, hi_x_ff, lo_y_ff, hi_y_ff;
   logic signed [PTW-1:0] dx_ff, dy_ff;
   logic signed [PTW-1:0] cl_x_ff, ch_x_ff, cl_y_ff, ch_y_ff;
   logic                  big_ff;
   ext_type               ext4_ff;

   assign rr = $signed({{(PTW-RADIUS_W){1'b0}}, m3_ff.r});

   always_ff @(posedge clock) begin
      if (en) begin
         lo_x_ff <= (pt_ff[PSX] < pt_ff[PEX]) ? pt_ff[PSX] : pt_ff[PEX];
         hi_x_ff <= (pt_ff[PSX] > pt_ff[PEX]) ? pt_ff[PSX] : pt_ff[PEX];
         lo_y_ff <= (pt_ff[PSY] < pt_ff[PEY]) ? pt_ff[PSY] : pt_ff[PEY];
         hi_y_ff <= (pt_ff[PSY] > pt_ff[PEY]) ? pt_ff[PSY] : pt_ff[PEY];
         dx_ff <= pt_ff[PSX] - pt_ff[PEX];
         dy_ff <= pt_ff[PSY] - pt_ff[PEY];
         cl_x_ff <= PTW'(m3_ff.cx) - rr;
         ch_x_ff <= PTW'(m3_ff.cx) + rr;
         cl_y_ff <= PTW'(m3_ff.cy) - rr;
         ch_y_ff <= PTW'(m3_ff.cy) + rr;
         big_ff <= m3_ff.r > lim_ff;
         ext4_ff <= m3_ff.ext;
      end
   end

   // degenerate test and extreme merge
   logic signed [PTW-1:0] tolp;
   logic                  degen;
   logic signed [PTW-1:0] bx0_ff, bx1_ff, by0_ff, by1_ff;

   always_comb begin
      tolp = $signed({{(PTW-TOL_W){1'b0}}, tol_ff});
      degen = (dx_ff <= tolp) && (dx_ff >= -tolp) &&
              (dy_ff <= tolp) && (dy_ff >= -tolp) && big_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bx0_ff <= (ext4_ff.xmin && !degen && cl_x_ff < lo_x_ff) ? cl_x_ff : lo_x_ff;
         bx1_ff <= (ext4_ff.xmax && !degen && ch_x_ff > hi_x_ff) ? ch_x_ff : hi_x_ff;
         by0_ff <= (ext4_ff.ymin && !degen && cl_y_ff < lo_y_ff) ? cl_y_ff : lo_y_ff;
         by1_ff <= (ext4_ff.ymax && !degen && ch_y_ff > hi_y_ff) ? ch_y_ff : hi_y_ff;
      end
   end

   // saturation
   box_type box_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         box_ff.min_x <= sat_coord(bx0_ff);
         box_ff.min_y <= sat_coord(by0_ff);
         box_ff.max_x <= sat_coord(bx1_ff);
         box_ff.max_y <= sat_coord(by1_ff);
      end
   end

   // output register and skid entry
   box_type out_ff;
   box_type out_in;
   box_type skid_ff;
   box_type skid_in;
   logic    out_v_in;
   logic    skid_v_in;
   logic    take;
   logic    arrive;

   always_comb begin
      take = out_v_ff && !rsp_stall;
      arrive = en && v_ff[LAST];
      out_v_in = out_v_ff && !take;
      out_in = out_ff;
      skid_v_in = skid_v_ff;
      skid_in = skid_ff;
      if (skid_v_ff && take) begin
         out_v_in = 1'b1;
         out_in = skid_ff;
         skid_v_in = 1'b0;
      end else if (arrive) begin
         if (!out_v_ff || take) begin
            out_v_in = 1'b1;
            out_in = box_ff;
         end else begin
            skid_v_in = 1'b1;
            skid_in = box_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_min_x = out_ff.min_x;
   assign rsp_min_y = out_ff.min_y;
   assign rsp_max_x = out_ff.max_x;
   assign rsp_max_y = out_ff.max_y;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held while output register empty");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && rsp_stall && v_ff[LAST]))
      else $error("skid filled without a blocked output");

   a_box_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_min_x <= rsp_max_x) && (rsp_min_y <= rsp_max_y))
      else $error("box edges out of order");

endmodule
